// ===== hw/rtl/lpfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfs_pkg
// Types and constants shared by the length-prefixed frame splitter.
// ----------------------------------------------------------------------------
package lpfs_pkg;

    localparam int HEADER_CHARS = 4;
    localparam int HPOS_W       = $clog2(HEADER_CHARS + 1);
    localparam int LEN_W        = 14;

    localparam logic [LEN_W-1:0] LEN_MAX = '1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        EV_NONE       = 2'd0,
        EV_INCOMPLETE = 2'd1,
        EV_HDR_ERROR  = 2'd2,
        EV_ZERO_FILL  = 2'd3
    } t_event;

    typedef enum logic [4:0] {
        PH_START   = 5'b00001,
        PH_SKIP    = 5'b00010,
        PH_HEADER  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_DROP    = 5'b10000
    } t_phase;

    typedef enum logic [3:0] {
        NS_BLANK  = 4'b0001,
        NS_SIGN   = 4'b0010,
        NS_DIGITS = 4'b0100,
        NS_STOP   = 4'b1000
    } t_nstage;

    typedef struct packed {
        t_phase             phase;
        logic [HPOS_W-1:0]  hpos;
        t_nstage            nstage;
        logic               digit_seen;
        logic [LEN_W-1:0]   acc;
        logic [LEN_W-1:0]   remaining;
        logic               copy_active;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:       PH_START,
        hpos:        '0,
        nstage:      NS_BLANK,
        digit_seen:  1'b0,
        acc:         '0,
        remaining:   '0,
        copy_active: 1'b1
    };

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             in_frame;
        logic             copy_byte;
        logic             frame_first;
        logic             frame_done;
        t_event           event_code;
        logic [LEN_W-1:0] payload_length;
    } t_result;

endpackage

// ===== hw/rtl/lpfs_if.sv =====
// ----------------------------------------------------------------------------
// lpfs request and result channels
// Valid/ready channels for input bytes and per-byte results.
// ----------------------------------------------------------------------------
interface lpfs_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_last;

    modport source (output valid, output data_byte, output buffer_last, input ready);
    modport sink   (input valid, input data_byte, input buffer_last, output ready);
endinterface

interface lpfs_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        in_frame;
    logic        copy_byte;
    logic        frame_first;
    logic        frame_done;
    logic [1:0]  event_code;
    logic [13:0] payload_length;

    modport source (output valid, output out_byte, output in_frame, output copy_byte,
                    output frame_first, output frame_done, output event_code,
                    output payload_length, input ready);
    modport sink   (input valid, input out_byte, input in_frame, input copy_byte,
                    input frame_first, input frame_done, input event_code,
                    input payload_length, output ready);
endinterface

// ===== hw/rtl/lpfs_step.sv =====
// ----------------------------------------------------------------------------
// lpfs_step
// Next-state and result logic for one buffer byte.
// ----------------------------------------------------------------------------
module lpfs_step
    import lpfs_pkg::*;
(
    input  t_state     i_state,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_state     o_state,
    output t_result    o_result
);

    logic                dig;
    logic                blank;
    logic                handled;
    logic [3:0]          dval;
    logic [LEN_W+3:0]    prod;
    logic [LEN_W-1:0]    acc_dig;

    assign dig   = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign blank = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
    assign dval  = 4'(i_byte - CH_ZERO);

    // acc*10 + digit, saturated; acc is taken from the frame-start-adjusted state
    always_comb begin
        logic [LEN_W-1:0] a;
        a = (i_state.phase == PH_HEADER) ? i_state.acc : '0;
        prod = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + (LEN_W+4)'(dval);
        acc_dig = (prod > (LEN_W+4)'(LEN_MAX)) ? LEN_MAX : prod[LEN_W-1:0];
    end

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.out_byte   = i_byte;
        o_result.event_code = EV_NONE;
        handled  = 1'b0;

        if (i_state.phase == PH_SKIP && i_byte == CH_NUL) begin
            o_result.event_code = EV_ZERO_FILL;
            handled = 1'b1;
        end else if (i_state.phase == PH_DROP) begin
            handled = 1'b1;
        end else if (i_state.phase != PH_HEADER && i_state.phase != PH_PAYLOAD) begin
            o_result.frame_first = 1'b1;
            o_state       = STATE_RESET;
            o_state.phase = PH_HEADER;
        end

        if (!handled) begin
            o_result.in_frame = 1'b1;
            if (i_byte == CH_NUL) begin
                o_state.copy_active = 1'b0;
            end
            o_result.copy_byte = o_state.copy_active;
            if (o_state.phase == PH_HEADER) begin
                if (o_state.hpos < HPOS_W'(HEADER_CHARS)) begin
                    if (i_byte == CH_NUL) begin
                        o_state.nstage = NS_STOP;
                    end else begin
                        case (o_state.nstage)
                            NS_BLANK: begin
                                if (i_byte == CH_PLUS) begin
                                    o_state.nstage = NS_SIGN;
                                end else if (dig) begin
                                    o_state.nstage     = NS_DIGITS;
                                    o_state.acc        = acc_dig;
                                    o_state.digit_seen = 1'b1;
                                end else if (!blank) begin
                                    o_state.nstage = NS_STOP;
                                end
                            end
                            NS_SIGN, NS_DIGITS: begin
                                if (dig) begin
                                    o_state.nstage     = NS_DIGITS;
                                    o_state.acc        = acc_dig;
                                    o_state.digit_seen = 1'b1;
                                end else begin
                                    o_state.nstage = NS_STOP;
                                end
                            end
                            default: ;
                        endcase
                    end
                    o_state.hpos = o_state.hpos + HPOS_W'(1);
                end else if (!o_state.digit_seen) begin
                    o_result.event_code = EV_HDR_ERROR;
                    o_state.phase       = PH_DROP;
                end else if (o_state.acc == '0) begin
                    o_result.frame_done = 1'b1;
                    o_state.phase       = PH_SKIP;
                end else begin
                    o_state.remaining = o_state.acc;
                    o_state.phase     = PH_PAYLOAD;
                end
            end else begin
                o_state.remaining = o_state.remaining - LEN_W'(1);
                if (o_state.remaining == '0) begin
                    o_result.frame_done     = 1'b1;
                    o_result.payload_length = o_state.acc;
                    o_state.phase           = PH_SKIP;
                end
            end
        end

        if (i_last) begin
            if (o_state.phase == PH_HEADER || o_state.phase == PH_PAYLOAD) begin
                o_result.event_code = EV_INCOMPLETE;
            end
            o_state.phase = PH_START;
        end
    end

endmodule

// ===== hw/rtl/length_prefixed_frame_splitter_core.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_splitter_core
// Splits read-buffer bytes into length-prefixed frames, one result per byte.
// ----------------------------------------------------------------------------
// channel  | dir | fields
// i_req    | in  | data_byte[7:0], buffer_last
// o_res    | out | out_byte, in_frame, copy_byte, frame_first, frame_done,
//          |     | event_code[1:0], payload_length[13:0]
//
// One byte per cycle sustained while o_res is ready; an input register, then a
// result register, with the frame state updated as a byte moves between them.
// Synchronous active-low reset clears the frame state to buffer start.
// A stall on o_res holds the result; i_req still takes a byte while the input
// register is free.
// ----------------------------------------------------------------------------
module length_prefixed_frame_splitter_core
    import lpfs_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    lpfs_req_if.sink     i_req,
    lpfs_res_if.source   o_res
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    t_state     r_state;
    t_state     n_state;
    t_result    w_res;
    logic       w_adv;

    assign w_adv       = !r_out_valid || o_res.ready;
    assign i_req.ready = !r_in_valid || w_adv;

    lpfs_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .i_last   (r_in_last),
        .o_state  (n_state),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (r_in_valid && w_adv) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_byte <= i_req.data_byte;
            r_in_last <= i_req.buffer_last;
        end
        if (r_in_valid && w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.out_byte       = r_out.out_byte;
    assign o_res.in_frame       = r_out.in_frame;
    assign o_res.copy_byte      = r_out.copy_byte;
    assign o_res.frame_first    = r_out.frame_first;
    assign o_res.frame_done     = r_out.frame_done;
    assign o_res.event_code     = r_out.event_code;
    assign o_res.payload_length = r_out.payload_length;

`ifndef SYNTHESIS
    a_first_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.frame_first && o_res.frame_done))
        else $error("frame start and frame end on the same byte");

    a_fill_outside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.event_code == EV_ZERO_FILL) |-> !o_res.in_frame)
        else $error("zero fill byte marked in frame");

    a_copy_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.copy_byte) |-> o_res.in_frame)
        else $error("copied byte outside a frame");

    a_len_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.payload_length != '0) |-> o_res.frame_done)
        else $error("payload length without frame end");

    a_drop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && w_adv && r_state.phase == PH_DROP) |=> !r_out.in_frame)
        else $error("dropped byte marked in frame");
`endif

endmodule

// ===== tb/sv/tb_length_prefixed_frame_splitter_core.sv =====
// ----------------------------------------------------------------------------
// tb_length_prefixed_frame_splitter_core
// Self-checking bench for the frame splitter. Read buffers made of headers,
// separators, payloads, zero fill and noise are sent byte by byte. A local
// copy of the frame state predicts every per-byte result. Random gaps fall on
// both channels, and at least once the sender holds off until the block has
// drained.
// ----------------------------------------------------------------------------
module tb_length_prefixed_frame_splitter_core;
    import lpfs_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int N_RANDOM     = 1000;
    localparam int FLUSH_CYCLES = 8;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         drain;
    } t_req_byte;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lpfs_req_if req_if();
    lpfs_res_if res_if();

    length_prefixed_frame_splitter_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    t_req_byte  req_q[$];
    t_result    results_due[$];
    logic [7:0] staged[$];

    int n_items    = 0;
    int errors     = 0;
    int idle_count = 0;
    int send_gap   = 0;
    int take_gap   = 0;
    bit calm       = 1'b0;
    bit req_taken  = 1'b0;

    // local frame state
    t_phase            sp_phase  = PH_START;
    logic [HPOS_W-1:0] sp_hpos   = '0;
    t_nstage           sp_nstage = NS_BLANK;
    logic              sp_digit  = 1'b0;
    logic [LEN_W-1:0]  sp_acc    = '0;
    logic [LEN_W-1:0]  sp_remain = '0;
    logic              sp_copy   = 1'b1;

    function automatic t_result split_byte(input logic [7:0] b, input logic last);
        t_result     r;
        logic        handled;
        logic        dig;
        logic        blank;
        int unsigned v;
        r = '0;
        r.out_byte = b;
        r.event_code = EV_NONE;
        handled = 1'b0;
        dig = (b >= CH_ZERO) && (b <= CH_NINE);
        blank = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
        if (sp_phase == PH_SKIP && b == CH_NUL) begin
            r.event_code = EV_ZERO_FILL;
            handled = 1'b1;
        end else if (sp_phase == PH_DROP) begin
            handled = 1'b1;
        end else if (sp_phase != PH_HEADER && sp_phase != PH_PAYLOAD) begin
            r.frame_first = 1'b1;
            sp_hpos = '0;
            sp_nstage = NS_BLANK;
            sp_digit = 1'b0;
            sp_acc = '0;
            sp_remain = '0;
            sp_copy = 1'b1;
            sp_phase = PH_HEADER;
        end
        if (!handled) begin
            r.in_frame = 1'b1;
            if (b == CH_NUL) sp_copy = 1'b0;
            r.copy_byte = sp_copy;
            if (sp_phase == PH_HEADER) begin
                if (sp_hpos < HPOS_W'(HEADER_CHARS)) begin
                    if (b == CH_NUL) begin
                        sp_nstage = NS_STOP;
                    end else begin
                        case (sp_nstage)
                            NS_BLANK: begin
                                if (blank) begin
                                end else if (b == CH_PLUS) begin
                                    sp_nstage = NS_SIGN;
                                end else if (dig) begin
                                    sp_nstage = NS_DIGITS;
                                end else begin
                                    sp_nstage = NS_STOP;
                                end
                            end
                            NS_SIGN, NS_DIGITS: begin
                                sp_nstage = dig ? NS_DIGITS : NS_STOP;
                            end
                            default: begin
                            end
                        endcase
                        if (dig && sp_nstage == NS_DIGITS) begin
                            v = int'(sp_acc) * 10 + int'(b - CH_ZERO);
                            sp_acc = (v > 32'(LEN_MAX)) ? LEN_MAX : v[LEN_W-1:0];
                            sp_digit = 1'b1;
                        end
                    end
                    sp_hpos = sp_hpos + HPOS_W'(1);
                end else if (!sp_digit) begin
                    r.event_code = EV_HDR_ERROR;
                    sp_phase = PH_DROP;
                end else if (sp_acc == '0) begin
                    r.frame_done = 1'b1;
                    sp_phase = PH_SKIP;
                end else begin
                    sp_remain = sp_acc;
                    sp_phase = PH_PAYLOAD;
                end
            end else begin
                sp_remain = sp_remain - LEN_W'(1);
                if (sp_remain == '0) begin
                    r.frame_done = 1'b1;
                    r.payload_length = sp_acc;
                    sp_phase = PH_SKIP;
                end
            end
        end
        if (last) begin
            if (sp_phase == PH_HEADER || sp_phase == PH_PAYLOAD) r.event_code = EV_INCOMPLETE;
            sp_phase = PH_START;
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (calm || p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_blank();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
    endfunction

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
        end
    endtask

    task automatic stage_byte(input logic [7:0] b);
        staged.insert(staged.size(), b);
    endtask

    task automatic send_staged(input bit drain);
        foreach (staged[i]) begin
            req_q.insert(req_q.size(), '{staged[i], i == staged.size() - 1, drain && i == 0});
        end
        n_items += staged.size();
        staged.delete();
    endtask

    // header, separator and payload of one frame; big picks a long length
    task automatic add_frame(input bit big);
        int nd, lim, len, sgn, nb, tail, d;
        logic [7:0] digs[4];
        logic [7:0] b;
        nd = big ? 4 : $urandom_range(1, 4);
        lim = (nd == 1) ? 9 : (nd == 2) ? 99 : (nd == 3) ? 999 : 9999;
        if (big) len = $urandom_range(1000, 9999);
        else if ($urandom_range(0, 29) == 0) len = $urandom_range(0, (lim < 300) ? lim : 300);
        else len = $urandom_range(0, (lim < 12) ? lim : 12);
        sgn = (nd < 4) ? $urandom_range(0, 1) : 0;
        nb = $urandom_range(0, 4 - nd - sgn);
        tail = 4 - nd - sgn - nb;
        repeat (nb) stage_byte(rand_blank());
        if (sgn) stage_byte(CH_PLUS);
        d = len;
        for (int i = nd - 1; i >= 0; i--) begin
            digs[i] = CH_ZERO + 8'(d % 10);
            d = d / 10;
        end
        for (int i = 0; i < nd; i++) stage_byte(digs[i]);
        repeat (tail) begin
            b = 8'($urandom_range(0, 255));
            if (b >= CH_ZERO && b <= CH_NINE) b = 8'h2D;
            stage_byte(b);
        end
        stage_byte(8'($urandom_range(0, 255)));
        if (big) len = $urandom_range(0, 20);
        repeat (len) stage_byte(($urandom_range(0, 7) == 0) ? CH_NUL : 8'($urandom_range(0, 255)));
    endtask

    // requests go out on the falling edge
    always @(negedge clk) begin
        t_req_byte it;
        if (rst_n) begin
            if (req_if.valid && !req_taken) begin
            end else if (send_gap > 0) begin
                req_if.valid <= 1'b0;
                send_gap--;
            end else if (req_q.size() > 0 && !(req_q[0].drain && results_due.size() > 0)) begin
                it = req_q.pop_front();
                req_if.data_byte <= it.data;
                req_if.buffer_last <= it.last;
                req_if.valid <= 1'b1;
                send_gap = pick_gap();
                if ($urandom_range(0, 149) == 0) calm = !calm;
            end else begin
                req_if.valid <= 1'b0;
            end
            if (take_gap > 0) begin
                res_if.ready <= 1'b0;
                take_gap--;
            end else begin
                res_if.ready <= 1'b1;
                take_gap = pick_gap();
            end
        end
    end

    // handshakes are sampled on the rising edge
    always @(posedge clk) begin
        t_result exp_r;
        req_taken = 1'b0;
        if (rst_n) begin
            if (req_if.valid && req_if.ready) begin
                req_taken = 1'b1;
                results_due.insert(results_due.size(),
                                   split_byte(req_if.data_byte, req_if.buffer_last));
            end
            if (res_if.valid && res_if.ready) begin
                if (results_due.size() == 0) begin
                    $error("result with no request pending: out_byte %0h", res_if.out_byte);
                    errors++;
                end else begin
                    exp_r = results_due.pop_front();
                    check_field("out_byte", 16'(exp_r.out_byte), 16'(res_if.out_byte));
                    check_field("in_frame", 16'(exp_r.in_frame), 16'(res_if.in_frame));
                    check_field("copy_byte", 16'(exp_r.copy_byte), 16'(res_if.copy_byte));
                    check_field("frame_first", 16'(exp_r.frame_first), 16'(res_if.frame_first));
                    check_field("frame_done", 16'(exp_r.frame_done), 16'(res_if.frame_done));
                    check_field("event_code", 16'(exp_r.event_code), 16'(res_if.event_code));
                    check_field("payload_length", 16'(exp_r.payload_length),
                                16'(res_if.payload_length));
                end
            end
            if (req_taken || (res_if.valid && res_if.ready)) idle_count = 0;
            else idle_count++;
            if (idle_count >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        int kind, nf;
        bit first_random;
        req_if.valid = 1'b0;
        req_if.data_byte = 8'h00;
        req_if.buffer_last = 1'b0;
        res_if.ready = 1'b0;

        // blank/plus/digit header, zero in payload, zero fill, zero-length frame
        staged = '{CH_TAB, CH_PLUS, 8'h32, CH_CR, 8'hFF, CH_NUL, 8'h41, CH_NUL,
                   CH_ZERO, CH_ZERO, CH_ZERO, CH_ZERO, CH_SPACE};
        send_staged(1'b0);
        // minus sign: header error, rest of buffer dropped
        staged = '{8'h2D, 8'h31, 8'h32, 8'h33, 8'h2E, 8'h37};
        send_staged(1'b1);
        // zero at buffer start, error on last byte
        staged = '{CH_NUL, CH_NINE, CH_NINE, CH_NINE, CH_SPACE};
        send_staged(1'b0);
        // buffer ends inside header
        staged = '{8'h31, 8'h32};
        send_staged(1'b0);

        first_random = 1'b1;
        while (n_items < N_RANDOM + 26) begin
            kind = $urandom_range(0, 19);
            if (kind < 17) begin
                nf = $urandom_range(1, 4);
                repeat (nf) begin
                    add_frame(1'b0);
                    if ($urandom_range(0, 9) < 3) begin
                        repeat ($urandom_range(1, 3)) stage_byte(CH_NUL);
                    end
                end
                if (kind >= 14) staged = staged[0:$urandom_range(0, staged.size() - 2)];
            end else if (kind == 17) begin
                add_frame(1'b1);
                staged = staged[0:$urandom_range(0, staged.size() - 2)];
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    case ($urandom_range(0, 5))
                        0: stage_byte(8'h2D);
                        1: stage_byte(CH_NUL);
                        2: stage_byte(rand_blank());
                        3: stage_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                        4: stage_byte(CH_PLUS);
                        default: stage_byte(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            send_staged(first_random || $urandom_range(0, 39) == 0);
            first_random = 1'b0;
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (req_q.size() != 0 || req_if.valid || results_due.size() != 0) @(posedge clk);
        repeat (FLUSH_CYCLES) @(posedge clk);

        if (errors == 0 && results_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
